FILE: sv/pcicfg_pkg.sv
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared constants, request codes and controller/datapath interface types
// for the PCI configuration address/data port.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

    // slot table and byte store geometry
    localparam int SLOTS     = 8;
    localparam int CFG_BYTES = 256;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEM_DEPTH = SLOTS * CFG_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // base address register window used during sizing
    localparam logic [7:0]  BAR_FIRST = 8'h10;
    localparam logic [7:0]  BAR_LAST  = 8'h24;
    localparam logic [31:0] ALL_ONES  = 32'hffff_ffff;

    // request codes
    typedef enum logic [2:0] {
        MODE_ADDR_WR   = 3'd0,
        MODE_ADDR_RD   = 3'd1,
        MODE_DATA_WR   = 3'd2,
        MODE_DATA_RD   = 3'd3,
        MODE_LOAD_SLOT = 3'd4,
        MODE_LOAD_CFG  = 3'd5,
        MODE_LOAD_SIZE = 3'd6,
        MODE_OTHER     = 3'd7
    } mode_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic clear_step;
        logic exec;
        logic lookup;
        logic fetch;
        logic finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_read;
        logic hit;
        logic in_range;
        logic last_byte;
        logic clear_done;
    } dp_status_t;

endpackage

FILE: sv/pcicfg_ctrl.sv
// ----------------------------------------------------------------------------
// pcicfg_ctrl
// Sequencer for the configuration port: clearing pass after reset, request
// execution, slot lookup, byte fetch and result hand-off.
// ----------------------------------------------------------------------------
module pcicfg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output pcicfg_pkg::dp_cmd_t    cmd,
    input  pcicfg_pkg::dp_status_t status
);
    import pcicfg_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOOKUP,
        ST_FETCH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // result valid: cleared on hand-off, set when a result is stored
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_valid_next = 1'b1;
        end
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_CLEAR: begin
                    if (status.clear_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= status.is_read ? ST_LOOKUP : ST_FINISH;
                end
                ST_LOOKUP: begin
                    state_reg <= (status.hit && status.in_range) ? ST_FETCH : ST_FINISH;
                end
                ST_FETCH: begin
                    if (status.last_byte) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // datapath commands
    always_comb begin
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.clear_step = (state_reg == ST_CLEAR);
        cmd.exec       = (state_reg == ST_EXEC);
        cmd.lookup     = (state_reg == ST_LOOKUP);
        cmd.fetch      = (state_reg == ST_FETCH);
        cmd.finish     = (state_reg == ST_FINISH) && out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sv/pcicfg_dp.sv
// ----------------------------------------------------------------------------
// pcicfg_dp
// Datapath: request registers, address and sizing state, slot table,
// config and size byte stores, byte assembly and the result register.
// ----------------------------------------------------------------------------
module pcicfg_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pcicfg_pkg::dp_cmd_t    cmd,
    output pcicfg_pkg::dp_status_t status,
    input  logic [2:0]             s_mode,
    input  logic [31:0]            s_value,
    input  logic [2:0]             s_access_len,
    input  logic [2:0]             s_slot,
    input  logic [7:0]             s_byte_offset,
    input  logic [7:0]             s_slot_bus,
    input  logic [4:0]             s_slot_device,
    input  logic [2:0]             s_slot_function,
    output logic [31:0]            m_read_data
);
    import pcicfg_pkg::*;

    // request registers
    mode_t       mode_reg;
    logic [31:0] value_reg;
    logic [1:0]  len_m1_reg;
    logic [2:0]  slot_reg;
    logic [7:0]  ofs_reg;
    logic [7:0]  bus_reg;
    logic [4:0]  dev_reg;
    logic [2:0]  fn_reg;

    // port state
    logic [31:0]      config_address_reg;
    logic             sizing_flag_reg;
    logic [SLOTS-1:0] slot_valid_reg;
    logic [7:0]       slot_bus_reg [SLOTS];
    logic [4:0]       slot_dev_reg [SLOTS];
    logic [2:0]       slot_fn_reg  [SLOTS];

    // read working registers
    logic              hit_reg;
    logic [MEM_AW-1:0] hit_base_reg;
    logic              use_size_reg;
    logic              in_range_reg;
    logic [1:0]        byte_cnt_reg;
    logic [31:0]       result_reg;
    logic [31:0]       out_data_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    // byte stores
    logic [7:0] cfg_mem  [MEM_DEPTH];
    logic [7:0] size_mem [MEM_DEPTH];
    logic [7:0] cfg_rd_reg;
    logic [7:0] size_rd_reg;

    logic [1:0]        len_m1_in;
    logic [7:0]        cfg_bus;
    logic [4:0]        cfg_dev;
    logic [2:0]        cfg_fn;
    logic [7:0]        cfg_regnum;
    logic              hit_c;
    logic [SLOT_W-1:0] hit_idx_c;
    logic              in_range_c;
    logic              use_size_c;
    logic              slot_ok;
    logic              ofs_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic [MEM_AW-1:0] ld_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              cfg_we;
    logic              size_we;
    logic [1:0]        rd_cnt;
    logic [8:0]        rd_byte;
    logic [MEM_AW-1:0] rd_addr;

    // access length clamped to 1..4, kept as length minus one
    always_comb begin
        if (s_access_len <= 3'd1) begin
            len_m1_in = 2'd0;
        end else if (s_access_len >= 3'd4) begin
            len_m1_in = 2'd3;
        end else begin
            len_m1_in = 2'(s_access_len - 3'd1);
        end
    end

    // address decode
    assign cfg_bus    = config_address_reg[23:16];
    assign cfg_dev    = config_address_reg[15:11];
    assign cfg_fn     = config_address_reg[10:8];
    assign cfg_regnum = config_address_reg[7:0];

    // slot search, lowest matching slot wins
    always_comb begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && slot_bus_reg[i] == cfg_bus &&
                slot_dev_reg[i] == cfg_dev && slot_fn_reg[i] == cfg_fn) begin
                hit_c     = 1'b1;
                hit_idx_c = SLOT_W'(i);
            end
        end
    end

    assign in_range_c = (32'(cfg_regnum) + 32'(len_m1_reg)) < 32'(CFG_BYTES);
    assign use_size_c = sizing_flag_reg && (cfg_regnum >= BAR_FIRST) &&
                        (cfg_regnum <= BAR_LAST);

    // load targets
    assign slot_ok  = 32'(slot_reg) < 32'(SLOTS);
    assign ofs_ok   = 32'(ofs_reg) < 32'(CFG_BYTES);
    assign slot_idx = SLOT_W'(slot_reg);
    assign ld_addr  = MEM_AW'(slot_reg) * MEM_AW'(CFG_BYTES) + MEM_AW'(ofs_reg);

    // write port: clearing pass or byte load
    assign wr_addr = cmd.clear_step ? clr_cnt_reg : ld_addr;
    assign wr_data = cmd.clear_step ? 8'd0 : value_reg[7:0];
    assign cfg_we  = cmd.clear_step ||
                     (cmd.exec && mode_reg == MODE_LOAD_CFG && slot_ok && ofs_ok);
    assign size_we = cmd.clear_step ||
                     (cmd.exec && mode_reg == MODE_LOAD_SIZE && slot_ok && ofs_ok);

    // read port runs one byte ahead of assembly
    assign rd_cnt  = cmd.fetch ? 2'(byte_cnt_reg + 2'd1) : byte_cnt_reg;
    assign rd_byte = {1'b0, cfg_regnum} + {7'd0, rd_cnt};
    assign rd_addr = hit_base_reg + MEM_AW'(rd_byte);

    always_ff @(posedge aclk) begin
        if (cfg_we) begin
            cfg_mem[wr_addr] <= wr_data;
        end
        cfg_rd_reg <= cfg_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[wr_addr] <= wr_data;
        end
        size_rd_reg <= size_mem[rd_addr];
    end

    // port control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            config_address_reg <= '0;
            sizing_flag_reg    <= 1'b0;
            slot_valid_reg     <= '0;
            clr_cnt_reg        <= '0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.exec) begin
                unique case (mode_reg)
                    MODE_ADDR_WR: begin
                        config_address_reg <= value_reg;
                    end
                    MODE_DATA_WR: begin
                        if (value_reg == ALL_ONES) begin
                            sizing_flag_reg <= 1'b1;
                        end
                    end
                    MODE_LOAD_SLOT: begin
                        if (slot_ok) begin
                            slot_valid_reg[slot_idx] <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            // any hit ends bar sizing
            if (cmd.lookup && hit_reg) begin
                sizing_flag_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= mode_t'(s_mode);
            value_reg  <= s_value;
            len_m1_reg <= len_m1_in;
            slot_reg   <= s_slot;
            ofs_reg    <= s_byte_offset;
            bus_reg    <= s_slot_bus;
            dev_reg    <= s_slot_device;
            fn_reg     <= s_slot_function;
        end
        if (cmd.exec) begin
            if (mode_reg == MODE_LOAD_SLOT && slot_ok) begin
                slot_bus_reg[slot_idx] <= bus_reg;
                slot_dev_reg[slot_idx] <= dev_reg;
                slot_fn_reg[slot_idx]  <= fn_reg;
            end
            result_reg   <= (mode_reg == MODE_ADDR_RD) ? config_address_reg : 32'd0;
            hit_reg      <= hit_c;
            hit_base_reg <= MEM_AW'(hit_idx_c) * MEM_AW'(CFG_BYTES);
            use_size_reg <= use_size_c;
            in_range_reg <= in_range_c;
            byte_cnt_reg <= 2'd0;
        end
        // miss answers all ones only at register zero
        if (cmd.lookup && !hit_reg) begin
            result_reg <= (cfg_regnum == 8'd0) ? ALL_ONES : 32'd0;
        end
        // little-endian byte assembly
        if (cmd.fetch) begin
            result_reg[8*byte_cnt_reg +: 8] <= use_size_reg ? size_rd_reg : cfg_rd_reg;
            byte_cnt_reg                    <= 2'(byte_cnt_reg + 2'd1);
        end
        if (cmd.finish) begin
            out_data_reg <= result_reg;
        end
    end

    // status to controller
    always_comb begin
        status.is_read    = (mode_reg == MODE_DATA_RD);
        status.hit        = hit_reg;
        status.in_range   = in_range_reg;
        status.last_byte  = (byte_cnt_reg == len_m1_reg);
        status.clear_done = (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1));
    end

    assign m_read_data = out_data_reg;

endmodule

FILE: sv/pci_config_space_port_unit.sv
// ----------------------------------------------------------------------------
// pci_config_space_port_unit
// PCI configuration address/data port with a device slot table and per-slot
// config and size byte stores.
//
//   channel   direction  handshake          payload
//   s_*       in         s_valid / s_ready  mode, value, access_len, slot,
//                                           byte_offset, slot_bus/device/function
//   m_*       out        m_valid / m_ready  read_data
//
// One request at a time. Writes, loads, address reads and other modes pass
// through the execute and finish states; a data read adds a slot lookup and,
// on an in-range hit, fetches the access_len bytes (clamped to 1..4), one byte per cycle
// from the single read port of the byte stores.
// After reset a clearing pass zeroes all SLOTS * CFG_BYTES entries of both
// byte stores, one entry a cycle, with s_ready low.
// A request is taken while the previous result still waits in the output
// register; a stalled m_ready holds the next result in the finish state.
// ----------------------------------------------------------------------------
module pci_config_space_port_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_value,
    input  logic [2:0]  s_access_len,
    input  logic [2:0]  s_slot,
    input  logic [7:0]  s_byte_offset,
    input  logic [7:0]  s_slot_bus,
    input  logic [4:0]  s_slot_device,
    input  logic [2:0]  s_slot_function,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data
);
    import pcicfg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    pcicfg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // datapath
    pcicfg_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_mode          (s_mode),
        .s_value         (s_value),
        .s_access_len    (s_access_len),
        .s_slot          (s_slot),
        .s_byte_offset   (s_byte_offset),
        .s_slot_bus      (s_slot_bus),
        .s_slot_device   (s_slot_device),
        .s_slot_function (s_slot_function),
        .m_read_data     (m_read_data)
    );

endmodule

FILE: sv/pcicfg_checker.sv
// ----------------------------------------------------------------------------
// pcicfg_checker
// Port-level checks on the configuration port, bound to the top level.
// ----------------------------------------------------------------------------
module pcicfg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one request in flight: no accept right after an accept
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous request in progress");

    // a new result only appears after a request was taken
    a_result_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without a request in progress");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("stalled result dropped or changed");

endmodule

bind pci_config_space_port_unit pcicfg_checker u_checker (.*);
